[rtl/core/assert_macros.svh]
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/thpc_pkg.sv]
package thpc_pkg;

   localparam int unsigned NumRegs = 6;

   // configuration register indexes
   localparam logic [2:0] REG_TEMP    = 3'd0;
   localparam logic [2:0] REG_PRESS_A = 3'd1;
   localparam logic [2:0] REG_PRESS_B = 3'd2;
   localparam logic [2:0] REG_PRESS_C = 3'd3;
   localparam logic [2:0] REG_HUM_A   = 3'd4;
   localparam logic [2:0] REG_HUM_B   = 3'd5;

   localparam int unsigned DivStages = 32;

   // unsigned 32/32 restoring divider step state
   typedef struct packed {
      logic [31:0] rem;
      logic [31:0] quo;
      logic [31:0] dvs;
      logic        post_shl;
   } div_state_type;

   function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned s);
      logic signed [31:0] t;
      t = $signed(x);
      return 32'(t >>> s);
   endfunction

   function automatic logic [31:0] mul(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] p;
      p = 64'(a) * 64'(b);
      return p[31:0];
   endfunction

   function automatic div_state_type div_step(input div_state_type s);
      div_state_type n;
      logic [32:0] trial;
      n = s;
      trial = {s.rem, s.quo[31]};
      n.quo = {s.quo[30:0], 1'b0};
      if (trial >= 33'(s.dvs)) begin
         n.rem = 32'(trial - 33'(s.dvs));
         n.quo[0] = 1'b1;
      end else begin
         n.rem = trial[31:0];
      end
      return n;
   endfunction

endpackage

[rtl/core/thpc_divider.sv]
// pipelined 32/32 unsigned divider, one quotient bit per stage, with sideband
module thpc_divider #(
   parameter int unsigned SideW = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic                         in_valid,
   input  thpc_pkg::div_state_type      in_state,
   input  logic [SideW-1:0]             in_side,
   output logic                         out_valid,
   output logic [31:0]                  out_quo,
   output logic [SideW-1:0]             out_side
);
   localparam int unsigned N = thpc_pkg::DivStages;

   thpc_pkg::div_state_type st_ff [N];
   logic [SideW-1:0]        side_ff [N];
   logic [N-1:0]            vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[N-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st_ff[0]   <= thpc_pkg::div_step(in_state);
         side_ff[0] <= in_side;
         for (int i = 1; i < N; i++) begin
            st_ff[i]   <= thpc_pkg::div_step(st_ff[i-1]);
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   assign out_valid = vld_ff[N-1];
   assign out_quo   = st_ff[N-1].post_shl ? {st_ff[N-1].quo[30:0], 1'b0}
                                          : st_ff[N-1].quo;
   assign out_side  = side_ff[N-1];
endmodule

[rtl/core/thp_sensor_compensation_top.sv]
// Sensor compensation: temperature, pressure and humidity, vendor 32-bit integer formulas.
// Input channel req_*: one transaction carries one raw sample set
//   (adc_temperature, adc_pressure, adc_humidity) packed in req_tdata.
// Output channel rsp_*: one transaction per input transaction, in order,
//   with temperature_centi, pressure_pa and humidity_q10 packed in rsp_tdata.
// Configuration: csr_we/csr_index/csr_wdata write one coefficient register
//   per cycle; write only while the pipeline is empty. Bad indexes are dropped.
// Throughput: one transaction per cycle unless rsp_tready stalls the output. Stages: 8 front,
//   32 divider stages, 3 back stages and the output register (44 register stages).
// The long pole is the pressure division, a restoring divider that resolves
//   one quotient bit per pipeline stage.
// Reset (synchronous, active high) clears all valid bits and coefficients.
// Stall: the whole pipeline advances only when the output register is empty
//   or being taken; a stalled rsp side freezes every stage so nothing is lost,
//   and req_tready drops in the same cycle.
module thp_sensor_compensation_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [19:0] adc_temperature, [39:20] adc_pressure, [55:40] adc_humidity
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [31:0] temperature_centi, [63:32] pressure_pa, [80:64] humidity_q10, zero pad
   output logic [87:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_wdata
);
   localparam int unsigned FrontN = 8;
   localparam int unsigned BackN  = 3;

   // coefficient registers
   logic [47:0] temp_ff, pa_ff, pb_ff, pc_ff;
   logic [31:0] ha_ff, hb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_ff <= '0; pa_ff <= '0; pb_ff <= '0; pc_ff <= '0;
         ha_ff <= '0; hb_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            thpc_pkg::REG_TEMP:    temp_ff <= csr_wdata;
            thpc_pkg::REG_PRESS_A: pa_ff   <= csr_wdata;
            thpc_pkg::REG_PRESS_B: pb_ff   <= csr_wdata;
            thpc_pkg::REG_PRESS_C: pc_ff   <= csr_wdata;
            thpc_pkg::REG_HUM_A:   ha_ff   <= csr_wdata[31:0];
            thpc_pkg::REG_HUM_B:   hb_ff   <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // coefficient fields, extended to 32 bits
   logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
   logic [31:0] h1, h2, h3, h4, h5, h6;
   assign t1 = {16'd0, temp_ff[15:0]};
   assign t2 = {{16{temp_ff[31]}}, temp_ff[31:16]};
   assign t3 = {{16{temp_ff[47]}}, temp_ff[47:32]};
   assign p1 = {16'd0, pa_ff[15:0]};
   assign p2 = {{16{pa_ff[31]}}, pa_ff[31:16]};
   assign p3 = {{16{pa_ff[47]}}, pa_ff[47:32]};
   assign p4 = {{16{pb_ff[15]}}, pb_ff[15:0]};
   assign p5 = {{16{pb_ff[31]}}, pb_ff[31:16]};
   assign p6 = {{16{pb_ff[47]}}, pb_ff[47:32]};
   assign p7 = {{16{pc_ff[15]}}, pc_ff[15:0]};
   assign p8 = {{16{pc_ff[31]}}, pc_ff[31:16]};
   assign p9 = {{16{pc_ff[47]}}, pc_ff[47:32]};
   assign h1 = {24'd0, ha_ff[7:0]};
   assign h2 = {{16{ha_ff[23]}}, ha_ff[23:8]};
   assign h3 = {{24{ha_ff[31]}}, ha_ff[31:24]};
   assign h4 = {{20{hb_ff[11]}}, hb_ff[11:0]};
   assign h5 = {{20{hb_ff[23]}}, hb_ff[23:12]};
   assign h6 = {{24{hb_ff[31]}}, hb_ff[31:24]};

   // global advance: output register empty or being drained
   logic advance;
   logic out_vld_ff;
   assign advance    = !out_vld_ff || rsp_tready;
   assign req_tready = advance;

   logic [FrontN-1:0] fv_ff;
   always_ff @(posedge clock) begin
      if (reset) fv_ff <= '0;
      else if (advance) fv_ff <= {fv_ff[FrontN-2:0], req_tvalid};
   end

   // ---------- front stages ----------
   logic [19:0] s1_ap, s2_ap, s3_ap, s4_ap, s5_ap;
   logic [15:0] s1_ah, s2_ah, s3_ah, s4_ah, s5_ah;
   logic [31:0] s1_m1, s1_dd;
   logic [31:0] s2_v1, s2_m2;
   logic [31:0] s3_v1, s3_m3;
   logic [31:0] s4_tf, s4_pv1, s4_hx;
   logic [31:0] s5_temp, s5_v2a, s5_p5m, s5_p2m;
   logic [31:0] s5_hxa, s5_b, s5_c;
   logic [31:0] s6_temp, s6_v2, s6_v1, s6_a, s6_bc;
   logic [19:0] s6_ap;
   logic [31:0] s7_temp, s7_v1, s7_pr, s7_a, s7_e;
   logic [31:0] s8_temp, s8_v1, s8_pr, s8_hx;

   logic [31:0] at, ap_w, ah_w;
   assign at   = {12'd0, req_tdata[19:0]};
   assign ap_w = {12'd0, req_tdata[39:20]};
   assign ah_w = {16'd0, req_tdata[55:40]};

   always_ff @(posedge clock) begin
      if (advance) begin
         // stage 1: v1 product and d
         s1_m1 <= thpc_pkg::mul((at >> 3) - (t1 << 1), t2);
         s1_dd <= (at >> 4) - t1;
         s1_ap <= ap_w[19:0];
         s1_ah <= ah_w[15:0];
         // stage 2
         s2_v1 <= thpc_pkg::asr(s1_m1, 11);
         s2_m2 <= thpc_pkg::mul(s1_dd, s1_dd);
         s2_ap <= s1_ap; s2_ah <= s1_ah;
         // stage 3
         s3_v1 <= s2_v1;
         s3_m3 <= thpc_pkg::mul(thpc_pkg::asr(s2_m2, 12), t3);
         s3_ap <= s2_ap; s3_ah <= s2_ah;
         // stage 4: fine temperature
         s4_tf  <= s3_v1 + thpc_pkg::asr(s3_m3, 14);
         s4_pv1 <= thpc_pkg::asr(s3_v1 + thpc_pkg::asr(s3_m3, 14), 1) - 32'd64000;
         s4_hx  <= s3_v1 + thpc_pkg::asr(s3_m3, 14) - 32'd76800;
         s4_ap <= s3_ap; s4_ah <= s3_ah;
         // stage 5: first products
         s5_temp <= thpc_pkg::mul(s4_tf, 32'd5);
         s5_v2a  <= thpc_pkg::mul(thpc_pkg::asr(s4_pv1, 2), thpc_pkg::asr(s4_pv1, 2));
         s5_p5m  <= thpc_pkg::mul(s4_pv1, p5);
         s5_p2m  <= thpc_pkg::mul(p2, s4_pv1);
         s5_hxa  <= thpc_pkg::mul(h5, s4_hx);
         s5_b    <= thpc_pkg::asr(thpc_pkg::mul(s4_hx, h6), 10);
         s5_c    <= thpc_pkg::asr(thpc_pkg::mul(s4_hx, h3), 11) + 32'd32768;
         s5_ap <= s4_ap; s5_ah <= s4_ah;
         // stage 6
         s6_temp <= thpc_pkg::asr(s5_temp + 32'd128, 8);
         s6_v2   <= thpc_pkg::asr(thpc_pkg::mul(thpc_pkg::asr(s5_v2a, 11), p6)
                    + (s5_p5m << 1), 2) + (p4 << 16);
         s6_v1   <= thpc_pkg::asr(thpc_pkg::asr(thpc_pkg::mul(p3,
                    thpc_pkg::asr(s5_v2a, 13)), 3) + thpc_pkg::asr(s5_p2m, 1), 18);
         s6_a    <= thpc_pkg::asr(((32'(s5_ah) << 14) - (h4 << 20) - s5_hxa)
                    + 32'd16384, 15);
         s6_bc   <= thpc_pkg::asr(thpc_pkg::mul(s5_b, s5_c), 10) + 32'd2097152;
         s6_ap   <= s5_ap;
         // stage 7
         s7_temp <= s6_temp;
         s7_v1   <= thpc_pkg::asr(thpc_pkg::mul(32'd32768 + s6_v1, p1), 15);
         s7_pr   <= thpc_pkg::mul((32'd1048576 - 32'(s6_ap)) - thpc_pkg::asr(s6_v2, 12),
                    32'd3125);
         s7_a    <= s6_a;
         s7_e    <= thpc_pkg::asr(thpc_pkg::mul(s6_bc, h2) + 32'd8192, 14);
         // stage 8
         s8_temp <= s7_temp;
         s8_v1   <= s7_v1;
         s8_pr   <= s7_pr;
         s8_hx   <= thpc_pkg::mul(s7_a, s7_e);
      end
   end

   // ---------- divider ----------
   localparam int unsigned SideW = 32 + 32 + 1;
   thpc_pkg::div_state_type div_in;
   logic [SideW-1:0] div_side_in, div_side_out;
   logic             div_vld;
   logic [31:0]      div_quo;
   logic             pr_hi;
   assign pr_hi = s8_pr[31];
   always_comb begin
      div_in.rem      = '0;
      div_in.quo      = pr_hi ? s8_pr : (s8_pr << 1);
      div_in.dvs      = s8_v1;
      div_in.post_shl = pr_hi;
   end
   assign div_side_in = {s8_v1 == 32'd0, s8_hx, s8_temp};

   thpc_divider #(.SideW(SideW)) u_div (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(fv_ff[FrontN-1]), .in_state(div_in), .in_side(div_side_in),
      .out_valid(div_vld), .out_quo(div_quo), .out_side(div_side_out)
   );

   // ---------- back stages ----------
   logic [BackN-1:0] bv_ff;
   logic [31:0] b1_temp, b1_pr, b1_hx, b1_sqa, b1_p8, b1_hq;
   logic        b1_z;
   logic [31:0] b2_temp, b2_pr, b2_v1, b2_v2, b2_p8, b2_hq;
   logic        b2_z;
   logic [31:0] b3_temp, b3_pr, b3_hx;
   logic [31:0] hq;
   assign hq = thpc_pkg::asr(div_side_out[63:32], 15);

   always_ff @(posedge clock) begin
      if (reset) bv_ff <= '0;
      else if (advance) bv_ff <= {bv_ff[BackN-2:0], div_vld};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b1_temp <= div_side_out[31:0];
         b1_hx   <= div_side_out[63:32];
         b1_z    <= div_side_out[64];
         b1_pr   <= div_quo;
         b1_sqa  <= thpc_pkg::mul(div_quo >> 3, div_quo >> 3);
         b1_p8   <= thpc_pkg::mul(div_quo >> 2, p8);
         b1_hq   <= thpc_pkg::mul(hq, hq);
         // stage b2
         b2_temp <= b1_temp;
         b2_z    <= b1_z;
         b2_pr   <= b1_pr;
         b2_v1   <= thpc_pkg::mul(p9, b1_sqa >> 13);
         b2_p8   <= thpc_pkg::asr(b1_p8, 13);
         b2_v2   <= b1_hx;
         b2_hq   <= thpc_pkg::asr(thpc_pkg::mul(thpc_pkg::asr(b1_hq, 7), h1), 4);
         // stage b3
         b3_temp <= b2_temp;
         b3_pr   <= b2_z ? 32'd0 : b2_pr + thpc_pkg::asr(thpc_pkg::asr(b2_v1, 12)
                    + b2_p8 + p7, 4);
         b3_hx   <= b2_v2 - b2_hq;
      end
   end

   logic [31:0] hclamp;
   always_comb begin
      if (b3_hx[31]) hclamp = '0;
      else if (b3_hx > 32'd419430400) hclamp = 32'd419430400;
      else hclamp = b3_hx;
   end

   // output register
   logic [87:0] out_data_ff;
   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else if (advance) out_vld_ff <= bv_ff[BackN-1];
   end
   always_ff @(posedge clock) begin
      if (advance) out_data_ff <= {7'd0, hclamp[28:12], b3_pr, b3_temp};
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
endmodule

[rtl/core/thpc_checker.sv]
`include "assert_macros.svh"
module thpc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [87:0] rsp_tdata
);
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "rsp dropped while stalled")
   `ASSERT_CLK(a_hum_range, clock, reset, !rsp_tvalid || rsp_tdata[80:64] <= 17'd102400, "humidity out of range")
   `ASSERT_CLK(a_pad_zero, clock, reset, !rsp_tvalid || rsp_tdata[87:81] == 7'd0, "pad bits set")
   `ASSERT_CLK(a_ready_stall, clock, reset, !(rsp_tvalid && !rsp_tready) || !req_tready, "ready during stall")
endmodule

bind thp_sensor_compensation_top thpc_checker u_chk (
   .clock(clock), .reset(reset), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
